// File: src/esc_pkg.sv
// Package for the epoch seconds to calendar converter.
// Holds field widths, time constants, command and state types and the month length table.
// No dependencies; used by esc_ctrl, esc_dp and epoch_seconds_to_calendar.
package esc_pkg;

	// Field widths.
	localparam int SECS_W  = 31;
	localparam int YEAR_W  = 11;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int IDX_W   = 3;

	// Calendar and time constants.
	localparam logic [YEAR_W-1:0]  BASE_YEAR      = 11'd1970;
	localparam logic [MONTH_W-1:0] LAST_MONTH     = 4'd12;
	localparam logic [SECS_W-1:0]  SECS_PER_MIN   = 31'd60;
	localparam logic [SECS_W-1:0]  SECS_PER_HOUR  = 31'd3600;
	localparam logic [SECS_W-1:0]  SECS_PER_DAY   = 31'd86400;
	localparam logic [SECS_W-1:0]  SECS_YEAR      = 31'd31536000;
	localparam logic [SECS_W-1:0]  SECS_LEAP_YEAR = 31'd31622400;

	// Residues of the base year, used to track the Gregorian leap rule.
	localparam logic [1:0] BASE_MOD4   = 2'd2;
	localparam logic [6:0] BASE_MOD100 = 7'd70;
	localparam logic [8:0] BASE_MOD400 = 9'd370;

	// First quotient bit of each digit extraction.
	localparam logic [IDX_W-1:0] DAY_TOP_BIT  = 3'd4;
	localparam logic [IDX_W-1:0] HOUR_TOP_BIT = 3'd4;
	localparam logic [IDX_W-1:0] MIN_TOP_BIT  = 3'd5;

	// Datapath operations.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_YEAR,
		OP_MONTH,
		OP_DAY,
		OP_HOUR,
		OP_MIN
	} op_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_YEAR,
		ST_MONTH,
		ST_DAY,
		ST_HOUR,
		ST_MIN
	} state_t;

	// Command from the controller to the datapath.
	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic ge;
		logic month_last;
	} status_t;

	// Length of a month in seconds.
	function automatic logic [SECS_W-1:0] month_secs(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [SECS_W-1:0] secs;
		case (m) inside
			4'd2: begin
				secs = leap ? 31'd2505600 : 31'd2419200;
			end
			4'd4, 4'd6, 4'd9, 4'd11: begin
				secs = 31'd2592000;
			end
			default: begin
				secs = 31'd2678400;
			end
		endcase
		return secs;
	endfunction

endpackage

// File: src/esc_dp.sv
// Datapath of the epoch seconds to calendar converter.
// One shared compare-and-subtract unit working on the remaining seconds, plus result registers.
// Depends on esc_pkg.
module esc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  esc_pkg::cmd_t                 cmd,
	input  logic [esc_pkg::SECS_W-1:0]    epoch_seconds,
	output esc_pkg::status_t              status,
	output logic [esc_pkg::YEAR_W-1:0]    year,
	output logic [esc_pkg::MONTH_W-1:0]   month,
	output logic [esc_pkg::DAY_W-1:0]     day,
	output logic [esc_pkg::HOUR_W-1:0]    hour,
	output logic [esc_pkg::MIN_W-1:0]     minute
);

	logic [esc_pkg::SECS_W-1:0]  rem_q;
	logic [esc_pkg::YEAR_W-1:0]  year_q;
	logic [esc_pkg::MONTH_W-1:0] month_q;
	logic [esc_pkg::DAY_W-1:0]   dayq_q;
	logic [esc_pkg::HOUR_W-1:0]  hour_q;
	logic [esc_pkg::MIN_W-1:0]   min_q;
	logic [1:0]                  mod4_q;
	logic [6:0]                  mod100_q;
	logic [8:0]                  mod400_q;
	logic                        leap;
	logic [esc_pkg::SECS_W-1:0]  sub;
	logic [esc_pkg::SECS_W:0]    diff;
	logic                        ge;

	// Gregorian rule from the running residues of the year.
	assign leap = ((mod4_q == 2'd0) && (mod100_q != 7'd0)) || (mod400_q == 9'd0);

	// Select the amount to take away in this step.
	always_comb begin
		case (cmd.op)
			esc_pkg::OP_YEAR: begin
				sub = leap ? esc_pkg::SECS_LEAP_YEAR : esc_pkg::SECS_YEAR;
			end
			esc_pkg::OP_MONTH: begin
				sub = esc_pkg::month_secs(month_q, leap);
			end
			esc_pkg::OP_DAY: begin
				sub = esc_pkg::SECS_PER_DAY << cmd.idx;
			end
			esc_pkg::OP_HOUR: begin
				sub = esc_pkg::SECS_PER_HOUR << cmd.idx;
			end
			esc_pkg::OP_MIN: begin
				sub = esc_pkg::SECS_PER_MIN << cmd.idx;
			end
			default: begin
				sub = '0;
			end
		endcase
	end

	// Shared compare and subtract.
	assign diff = {1'b0, rem_q} - {1'b0, sub};
	assign ge   = ~diff[esc_pkg::SECS_W];

	assign status.ge         = ge;
	assign status.month_last = (month_q == esc_pkg::LAST_MONTH);

	// Year, month and leap residues are kept under reset so the leap logic is always defined.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q   <= esc_pkg::BASE_YEAR;
			month_q  <= 4'd1;
			mod4_q   <= esc_pkg::BASE_MOD4;
			mod100_q <= esc_pkg::BASE_MOD100;
			mod400_q <= esc_pkg::BASE_MOD400;
		end else begin
			case (cmd.op)
				esc_pkg::OP_LOAD: begin
					year_q   <= esc_pkg::BASE_YEAR;
					month_q  <= 4'd1;
					mod4_q   <= esc_pkg::BASE_MOD4;
					mod100_q <= esc_pkg::BASE_MOD100;
					mod400_q <= esc_pkg::BASE_MOD400;
				end
				esc_pkg::OP_YEAR: begin
					if (ge) begin
						year_q   <= year_q + 11'd1;
						mod4_q   <= mod4_q + 2'd1;
						mod100_q <= (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
						mod400_q <= (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
					end
				end
				esc_pkg::OP_MONTH: begin
					if (ge && !status.month_last) begin
						month_q <= month_q + 4'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Remaining seconds and the quotient digits.
	always_ff @(posedge clk) begin
		case (cmd.op)
			esc_pkg::OP_LOAD: begin
				rem_q  <= epoch_seconds;
				dayq_q <= '0;
				hour_q <= '0;
				min_q  <= '0;
			end
			esc_pkg::OP_YEAR: begin
				if (ge) begin
					rem_q <= diff[esc_pkg::SECS_W-1:0];
				end
			end
			esc_pkg::OP_MONTH: begin
				if (ge && !status.month_last) begin
					rem_q <= diff[esc_pkg::SECS_W-1:0];
				end
			end
			esc_pkg::OP_DAY: begin
				if (ge) begin
					rem_q          <= diff[esc_pkg::SECS_W-1:0];
					dayq_q[cmd.idx] <= 1'b1;
				end
			end
			esc_pkg::OP_HOUR: begin
				if (ge) begin
					rem_q          <= diff[esc_pkg::SECS_W-1:0];
					hour_q[cmd.idx] <= 1'b1;
				end
			end
			esc_pkg::OP_MIN: begin
				if (ge) begin
					rem_q         <= diff[esc_pkg::SECS_W-1:0];
					min_q[cmd.idx] <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Result fields; the day of month counts from one.
	assign year   = year_q;
	assign month  = month_q;
	assign day    = dayq_q + 5'd1;
	assign hour   = hour_q;
	assign minute = min_q;

	// The residues must follow the year register, and the month must stay in range.
	a_mod4: assert property (@(posedge clk) disable iff (!arst_n)
		mod4_q == year_q[1:0])
		else $error("mod 4 residue out of step with year");
	a_mod100: assert property (@(posedge clk) disable iff (!arst_n)
		32'(mod100_q) == 32'(year_q) % 100)
		else $error("mod 100 residue out of step with year");
	a_month: assert property (@(posedge clk) disable iff (!arst_n)
		(month_q >= 4'd1) && (month_q <= esc_pkg::LAST_MONTH))
		else $error("month register out of range");

endmodule

// File: src/esc_ctrl.sv
// Controller of the epoch seconds to calendar converter.
// Sequences the year walk, the month walk and the day, hour and minute digit steps.
// Depends on esc_pkg.
module esc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  esc_pkg::status_t status,
	output esc_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             done
);

	esc_pkg::state_t              state_q;
	esc_pkg::state_t              state_d;
	logic [esc_pkg::IDX_W-1:0]    idx_q;
	logic                         done_q;
	logic                         last_step;

	assign last_step = (idx_q == '0);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			esc_pkg::ST_IDLE: begin
				if (start) begin
					state_d = esc_pkg::ST_YEAR;
				end
			end
			esc_pkg::ST_YEAR: begin
				if (!status.ge) begin
					state_d = esc_pkg::ST_MONTH;
				end
			end
			esc_pkg::ST_MONTH: begin
				if (!status.ge || status.month_last) begin
					state_d = esc_pkg::ST_DAY;
				end
			end
			esc_pkg::ST_DAY: begin
				if (last_step) begin
					state_d = esc_pkg::ST_HOUR;
				end
			end
			esc_pkg::ST_HOUR: begin
				if (last_step) begin
					state_d = esc_pkg::ST_MIN;
				end
			end
			esc_pkg::ST_MIN: begin
				if (last_step) begin
					state_d = esc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = esc_pkg::ST_IDLE;
			end
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd.idx = idx_q;
		case (state_q)
			esc_pkg::ST_IDLE: begin
				cmd.op = start ? esc_pkg::OP_LOAD : esc_pkg::OP_NONE;
			end
			esc_pkg::ST_YEAR: begin
				cmd.op = esc_pkg::OP_YEAR;
			end
			esc_pkg::ST_MONTH: begin
				cmd.op = esc_pkg::OP_MONTH;
			end
			esc_pkg::ST_DAY: begin
				cmd.op = esc_pkg::OP_DAY;
			end
			esc_pkg::ST_HOUR: begin
				cmd.op = esc_pkg::OP_HOUR;
			end
			esc_pkg::ST_MIN: begin
				cmd.op = esc_pkg::OP_MIN;
			end
			default: begin
				cmd.op = esc_pkg::OP_NONE;
			end
		endcase
	end

	assign busy = (state_q != esc_pkg::ST_IDLE);
	assign done = done_q;

	// State, digit index and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= esc_pkg::ST_IDLE;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == esc_pkg::ST_MIN) && last_step;
			if (state_d != state_q) begin
				case (state_d)
					esc_pkg::ST_DAY: begin
						idx_q <= esc_pkg::DAY_TOP_BIT;
					end
					esc_pkg::ST_HOUR: begin
						idx_q <= esc_pkg::HOUR_TOP_BIT;
					end
					esc_pkg::ST_MIN: begin
						idx_q <= esc_pkg::MIN_TOP_BIT;
					end
					default: begin
						idx_q <= '0;
					end
				endcase
			end else if (!last_step) begin
				idx_q <= idx_q - 3'd1;
			end
		end
	end

	// The strobe lasts one cycle and only ends a conversion.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == esc_pkg::ST_IDLE))
		else $error("result strobe outside idle");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && (state_q == esc_pkg::ST_YEAR)))
		else $error("accepted item did not start the year walk");

endmodule

// File: src/epoch_seconds_to_calendar.sv
// Channel   Ports                                   Handshake
// input     start, epoch_seconds                    taken when start is high and busy is low
// result    done, year, month, day, hour, minute    valid for the one cycle that done is high
//
// The time from acceptance to the done strobe grows with the number of whole years (up to 68) and
// of month steps (up to 12) to walk. It is set by the single shared compare-and-subtract unit,
// which takes one step per cycle for each year, each month and each quotient bit of day, hour
// and minute. After reset the block is idle and ready. The receiver cannot stall; a new item
// may be accepted in the cycle that done is high.
// Top level of the epoch seconds to calendar converter; depends on esc_pkg, esc_ctrl and esc_dp.
module epoch_seconds_to_calendar (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [esc_pkg::SECS_W-1:0]  epoch_seconds,
	output logic                        busy,
	output logic                        done,
	output logic [esc_pkg::YEAR_W-1:0]  year,
	output logic [esc_pkg::MONTH_W-1:0] month,
	output logic [esc_pkg::DAY_W-1:0]   day,
	output logic [esc_pkg::HOUR_W-1:0]  hour,
	output logic [esc_pkg::MIN_W-1:0]   minute
);

	esc_pkg::cmd_t    cmd;
	esc_pkg::status_t status;

	// Sequencer.
	esc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Arithmetic and result registers.
	esc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.epoch_seconds (epoch_seconds),
		.status        (status),
		.year          (year),
		.month         (month),
		.day           (day),
		.hour          (hour),
		.minute        (minute)
	);

endmodule
